// ===== sv/sdspi_pkg.sv =====
// Shared types, codes and constants for the SD card SPI-mode sequencer.
package sdspi_pkg;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned WAKE_BYTES      = 10;
  localparam int unsigned WRITE_GAP_BYTES = 100;
  localparam int unsigned LIMIT_W         = 16;
  localparam int unsigned PHASE_W         = 4;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 16'd200;

  // Operation codes of an input beat
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_XFER  = 2'd3;

  // Operation kinds held in state
  localparam logic [1:0] KIND_CMD0  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_CMD1  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_CARD   = 3'd1;
  localparam logic [2:0] ST_CMD0_FAIL = 3'd2;
  localparam logic [2:0] ST_CMD1_FAIL = 3'd3;
  localparam logic [2:0] ST_READ_FAIL = 3'd4;
  localparam logic [2:0] ST_WR_FAIL   = 3'd5;
  localparam logic [2:0] ST_REJECTED  = 3'd6;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_WAKE       = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CMD_DUMMY  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_CMD_SEND   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_CMD_POLL   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_GAP        = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FINAL      = 4'd6;
  localparam logic [PHASE_W-1:0] PH_TOKEN_WAIT = 4'd7;
  localparam logic [PHASE_W-1:0] PH_READ_DATA  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CRC        = 4'd9;
  localparam logic [PHASE_W-1:0] PH_WR_GAP     = 4'd10;
  localparam logic [PHASE_W-1:0] PH_WR_TOKEN   = 4'd11;
  localparam logic [PHASE_W-1:0] PH_WR_DATA    = 4'd12;
  localparam logic [PHASE_W-1:0] PH_WR_RESP    = 4'd13;
  localparam logic [PHASE_W-1:0] PH_WR_BUSY    = 4'd14;

  // Protocol bytes
  localparam logic [7:0] CMD0_BYTE    = 8'h40;
  localparam logic [7:0] CMD1_BYTE    = 8'h41;
  localparam logic [7:0] CMD17_BYTE   = 8'h51;
  localparam logic [7:0] CMD24_BYTE   = 8'h58;
  localparam logic [7:0] CMD0_CRC     = 8'h95;
  localparam logic [7:0] DATA_TOKEN   = 8'hFE;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] R1_IDLE      = 8'h01;
  localparam logic [7:0] R1_READY     = 8'h00;
  localparam logic [7:0] DRESP_MASK   = 8'h1F;
  localparam logic [7:0] DRESP_OK     = 8'h05;

  typedef struct packed {
    logic [1:0]  operation;
    logic [22:0] sector;
    logic [8:0]  window_start;
    logic [9:0]  window_length;
    logic        card_present;
    logic [7:0]  miso_byte;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic       exchange;
    logic [7:0] mosi_byte;
    logic       select_active;
    logic       fast_clock;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [8:0] byte_index;
    logic       need_write_data;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] card_response;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [1:0]         op_kind;
    logic [9:0]         byte_count;
    logic [LIMIT_W-1:0] retry_count;
    logic [LIMIT_W-1:0] poll_count;
    logic [22:0]        sector;
    logic [8:0]         window_first;
    logic [9:0]         window_end;
    logic [7:0]         last_response;
    logic               clock_is_fast;
  } seq_state_t;

endpackage

// ===== sv/sdspi_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface sdspi_in_if;
  import sdspi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_out_if;
  import sdspi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sdspi_step.sv =====
// Next-state and result logic of the sequencer for one input beat.
module sdspi_step (
  input  sdspi_pkg::seq_state_t         st,
  input  sdspi_pkg::in_item_t           item,
  input  logic [sdspi_pkg::LIMIT_W-1:0] retry_limit,
  output sdspi_pkg::seq_state_t         st_next,
  output sdspi_pkg::out_item_t          res
);
  import sdspi_pkg::*;

  logic [LIMIT_W-1:0] lim;
  logic [LIMIT_W-1:0] poll_next;
  logic [LIMIT_W-1:0] retry_next;
  logic [7:0]         want;
  logic [10:0]        wend;
  logic [9:0]         count_inc;

  function automatic logic [7:0] cmd_byte(input logic [1:0] kind, input logic [22:0] sec,
                                          input logic [9:0] k);
    logic [7:0] b;
    b = IDLE_BYTE;
    unique case (k)
      10'd0: begin
        unique case (kind)
          KIND_CMD0: b = CMD0_BYTE;
          KIND_CMD1: b = CMD1_BYTE;
          KIND_READ: b = CMD17_BYTE;
          default:   b = CMD24_BYTE;
        endcase
      end
      10'd1:   b = sec[22:15];
      10'd2:   b = sec[14:7];
      10'd3:   b = {sec[6:0], 1'b0};
      10'd4:   b = 8'h00;
      default: b = (kind == KIND_CMD0) ? CMD0_CRC : IDLE_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] fail_code(input logic [1:0] kind);
    logic [2:0] c;
    unique case (kind)
      KIND_CMD0: c = ST_CMD0_FAIL;
      KIND_READ: c = ST_READ_FAIL;
      KIND_WRITE: c = ST_WR_FAIL;
      default:   c = ST_CMD1_FAIL;
    endcase
    return c;
  endfunction

  // A zero limit acts as one
  assign lim        = (retry_limit == '0) ? LIMIT_W'(1) : retry_limit;
  assign poll_next  = st.poll_count + LIMIT_W'(1);
  assign retry_next = st.retry_count + LIMIT_W'(1);
  assign want       = (st.op_kind == KIND_CMD0) ? R1_IDLE : R1_READY;
  assign wend       = {2'b00, item.window_start} + {1'b0, item.window_length};
  assign count_inc  = st.byte_count + 10'd1;

  always_comb begin
    st_next = st;
    res     = '0;

    unique case (item.operation)
      OP_INIT: begin
        if (!item.card_present) begin
          st_next.phase = PH_IDLE;
          res.done_res  = 1'b1;
          res.status    = ST_NO_CARD;
        end else begin
          st_next.clock_is_fast = 1'b0;
          st_next.op_kind       = KIND_CMD0;
          st_next.sector        = '0;
          st_next.byte_count    = '0;
          st_next.phase         = PH_WAKE;
        end
      end
      OP_READ, OP_WRITE: begin
        st_next.op_kind = item.operation;
        st_next.sector  = item.sector;
        if (item.operation == OP_READ) begin
          st_next.window_first = item.window_start;
          st_next.window_end   = (wend > 11'(SECTOR_BYTES)) ? 10'(SECTOR_BYTES) : wend[9:0];
        end else begin
          st_next.window_first = '0;
          st_next.window_end   = '0;
        end
        st_next.retry_count = '0;
        st_next.phase       = PH_CMD_DUMMY;
      end
      default: begin
        unique case (st.phase)
          PH_WAKE: begin
            st_next.byte_count = count_inc;
            if (count_inc >= 10'(WAKE_BYTES)) begin
              st_next.retry_count = '0;
              st_next.phase       = PH_CMD_DUMMY;
            end
          end
          PH_CMD_DUMMY: begin
            st_next.byte_count = '0;
            st_next.phase      = PH_CMD_SEND;
          end
          PH_CMD_SEND: begin
            st_next.byte_count = count_inc;
            if (count_inc >= 10'd6) begin
              st_next.poll_count = '0;
              st_next.phase      = PH_CMD_POLL;
            end
          end
          PH_CMD_POLL: begin
            st_next.poll_count    = poll_next;
            st_next.last_response = item.miso_byte;
            // keep polling while the card holds the line high
            if (!(item.miso_byte == IDLE_BYTE && poll_next < lim)) begin
              st_next.retry_count = retry_next;
              if (retry_next == lim) begin
                st_next.phase     = PH_IDLE;
                res.done_res      = 1'b1;
                res.status        = fail_code(st.op_kind);
                res.card_response = (st.op_kind == KIND_WRITE) ? item.miso_byte : 8'h00;
              end else if (item.miso_byte != want) begin
                st_next.phase = PH_CMD_DUMMY;
              end else begin
                unique case (st.op_kind)
                  KIND_CMD0: st_next.phase = PH_GAP;
                  KIND_CMD1: begin
                    st_next.clock_is_fast = 1'b1;
                    st_next.phase         = PH_FINAL;
                  end
                  KIND_READ: st_next.phase = PH_TOKEN_WAIT;
                  default: begin
                    st_next.byte_count = '0;
                    st_next.phase      = PH_WR_GAP;
                  end
                endcase
              end
            end
          end
          PH_GAP: begin
            st_next.op_kind     = KIND_CMD1;
            st_next.retry_count = '0;
            st_next.phase       = PH_CMD_DUMMY;
          end
          PH_FINAL: begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_OK;
          end
          PH_TOKEN_WAIT: begin
            if (item.miso_byte == DATA_TOKEN) begin
              st_next.byte_count = '0;
              st_next.phase      = PH_READ_DATA;
            end
          end
          PH_READ_DATA: begin
            if (st.byte_count >= {1'b0, st.window_first} && st.byte_count < st.window_end) begin
              res.read_valid = 1'b1;
              res.read_byte  = item.miso_byte;
              res.byte_index = st.byte_count[8:0];
            end
            st_next.byte_count = count_inc;
            if (count_inc >= 10'(SECTOR_BYTES)) begin
              st_next.byte_count = '0;
              st_next.phase      = PH_CRC;
            end
          end
          PH_CRC: begin
            st_next.byte_count = count_inc;
            if (count_inc >= 10'd2) begin
              st_next.phase = (st.op_kind == KIND_WRITE) ? PH_WR_RESP : PH_FINAL;
            end
          end
          PH_WR_GAP: begin
            st_next.byte_count = count_inc;
            if (count_inc >= 10'(WRITE_GAP_BYTES)) begin
              st_next.phase = PH_WR_TOKEN;
            end
          end
          PH_WR_TOKEN: begin
            st_next.byte_count = '0;
            st_next.phase      = PH_WR_DATA;
          end
          PH_WR_DATA: begin
            st_next.byte_count = count_inc;
            if (count_inc >= 10'(SECTOR_BYTES)) begin
              st_next.byte_count = '0;
              st_next.phase      = PH_CRC;
            end
          end
          PH_WR_RESP: begin
            if ((item.miso_byte & DRESP_MASK) != DRESP_OK) begin
              st_next.phase = PH_IDLE;
              res.done_res  = 1'b1;
              res.status    = ST_REJECTED;
            end else begin
              st_next.phase = PH_WR_BUSY;
            end
          end
          PH_WR_BUSY: begin
            if (item.miso_byte == IDLE_BYTE) begin
              st_next.phase = PH_FINAL;
            end
          end
          default: st_next.phase = PH_IDLE;
        endcase
      end
    endcase

    // Request the next exchange for the phase just entered
    if (st_next.phase != PH_IDLE) begin
      res.exchange      = 1'b1;
      res.mosi_byte     = IDLE_BYTE;
      res.select_active = 1'b1;
      unique case (st_next.phase)
        PH_WAKE, PH_CMD_DUMMY, PH_GAP, PH_FINAL: res.select_active = 1'b0;
        PH_CMD_SEND: res.mosi_byte = cmd_byte(st_next.op_kind, st_next.sector,
                                              st_next.byte_count);
        PH_WR_TOKEN: begin
          res.mosi_byte       = DATA_TOKEN;
          res.need_write_data = 1'b1;
          res.byte_index      = '0;
        end
        PH_WR_DATA: begin
          res.mosi_byte = item.write_data;
          if (st_next.byte_count < 10'(SECTOR_BYTES - 1)) begin
            res.need_write_data = 1'b1;
            res.byte_index      = st_next.byte_count[8:0] + 9'd1;
          end
        end
        default: ;
      endcase
    end

    res.fast_clock = st_next.clock_is_fast;
  end

endmodule

// ===== sv/sd_spi_block_sequencer_top.sv =====
// Top level of the SD card SPI-mode host sequencer.
//
//   channel   dir   handshake      beat
//   in_ch     in    valid/ready    one start command or one finished SPI byte
//   out_ch    out   valid/ready    the next SPI byte request, read data or done
//   cfg       in    write enable   retry limit
//
// One beat per clock sustained while out_ch does not stall; a taken input beat waits in the
// input register while the step logic computes its result, which loads the result register.
// Every beat yields exactly one result beat.
// A stall on out_ch holds the result register, then the input register, then drops
// in_ch.ready. Reset (rst, synchronous) empties both registers and idles the sequencer.
module sd_spi_block_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  sdspi_in_if.sink                      in_ch,
  sdspi_out_if.source                   out_ch,
  input  logic                          cfg_write_en,
  input  logic [sdspi_pkg::LIMIT_W-1:0] cfg_write_data
);
  import sdspi_pkg::*;

  localparam seq_state_t STATE_RESET = '{
    phase:         PH_IDLE,
    op_kind:       KIND_CMD0,
    byte_count:    10'd0,
    retry_count:   '0,
    poll_count:    '0,
    sector:        23'd0,
    window_first:  9'd0,
    window_end:    10'd0,
    last_response: IDLE_BYTE,
    clock_is_fast: 1'b0
  };

  logic [LIMIT_W-1:0] retry_limit;
  logic               in_valid;
  in_item_t           in_data;
  logic               out_valid;
  out_item_t          out_data;
  seq_state_t         state;
  seq_state_t         state_next;
  out_item_t          res;
  logic               advance;

  assign advance      = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !in_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  sdspi_step u_step (
    .st          (state),
    .item        (in_data),
    .retry_limit (retry_limit),
    .st_next     (state_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_write_en) begin
      retry_limit <= cfg_write_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data <= in_ch.data;
    end
  end

  // Sequencer state advances with the beat moving into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_done_no_exchange: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.exchange))
    else $error("done result also requests an exchange");

  a_read_selected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_valid) |-> (out_data.exchange && out_data.select_active))
    else $error("read byte delivered without a selected exchange");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (advance && res.done_res) |=> (state.phase == PH_IDLE))
    else $error("sequencer not idle after a done result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(state))
    else $error("sequencer state moved while the result was stalled");
`endif

endmodule

// ===== dv/tb_sd_spi_block_sequencer_top.sv =====
// Self-checking testbench for the SD card SPI-mode host sequencer top level.
module tb_sd_spi_block_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PIPE_DEPTH  = 2;

  // Shadow of the sequencer: predicts the exchange each beat leads to and checks it
  class sd_sequencer_shadow;
    logic [LIMIT_W-1:0] attempt_limit;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         op_kind;
    logic [9:0]         byte_count;
    logic [LIMIT_W-1:0] retry_count;
    logic [LIMIT_W-1:0] poll_count;
    logic [31:0]        byte_address;
    logic [8:0]         window_first;
    logic [9:0]         window_end;
    logic [7:0]         last_response;
    logic               clock_fast;

    out_item_t   next_exchange_q[$];
    int unsigned mismatches;
    int unsigned beats_taken;
    int unsigned results_checked;
    int unsigned window_bytes;
    int unsigned payload_requests;
    int unsigned finished_by_status[8];

    function new();
      attempt_limit = RETRY_LIMIT_RESET;
      phase         = PH_IDLE;
      op_kind       = KIND_CMD0;
      byte_count    = '0;
      retry_count   = '0;
      poll_count    = '0;
      byte_address  = '0;
      window_first  = '0;
      window_end    = '0;
      last_response = IDLE_BYTE;
      clock_fast    = 1'b0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      attempt_limit = v;
    endfunction

    function bit seq_idle();
      return phase == PH_IDLE;
    endfunction

    function int unsigned pending();
      return next_exchange_q.size();
    endfunction

    function logic [LIMIT_W-1:0] eff_limit();
      return (attempt_limit == '0) ? LIMIT_W'(1) : attempt_limit;
    endfunction

    function void finish_op(inout out_item_t r, input logic [2:0] st);
      phase = PH_IDLE;
      r.done_res = 1'b1;
      r.status = st;
      r.card_response = (st == ST_WR_FAIL) ? last_response : 8'h00;
      finished_by_status[st]++;
    endfunction

    function void begin_command();
      retry_count = '0;
      phase = PH_CMD_DUMMY;
    endfunction

    function logic [7:0] command_byte();
      case (byte_count)
        10'd0: begin
          case (op_kind)
            KIND_CMD0: return CMD0_BYTE;
            KIND_CMD1: return CMD1_BYTE;
            KIND_READ: return CMD17_BYTE;
            default:   return CMD24_BYTE;
          endcase
        end
        10'd1: return byte_address[31:24];
        10'd2: return byte_address[23:16];
        10'd3: return byte_address[15:8];
        10'd4: return byte_address[7:0];
        default: return (op_kind == KIND_CMD0) ? CMD0_CRC : IDLE_BYTE;
      endcase
    endfunction

    function void poll_response(inout out_item_t r, input logic [7:0] m);
      logic [LIMIT_W-1:0] lim;
      logic [7:0] want;
      lim = eff_limit();
      want = (op_kind == KIND_CMD0) ? R1_IDLE : R1_READY;
      poll_count++;
      last_response = m;
      if (m == IDLE_BYTE && poll_count < lim) return;
      retry_count++;
      // the last allowed attempt fails even with a good answer
      if (retry_count == lim) begin
        case (op_kind)
          KIND_CMD0:  finish_op(r, ST_CMD0_FAIL);
          KIND_READ:  finish_op(r, ST_READ_FAIL);
          KIND_WRITE: finish_op(r, ST_WR_FAIL);
          default:    finish_op(r, ST_CMD1_FAIL);
        endcase
        return;
      end
      if (m != want) begin
        phase = PH_CMD_DUMMY;
        return;
      end
      case (op_kind)
        KIND_CMD0: phase = PH_GAP;
        KIND_CMD1: begin
          clock_fast = 1'b1;
          phase = PH_FINAL;
        end
        KIND_READ: phase = PH_TOKEN_WAIT;
        default: begin
          byte_count = '0;
          phase = PH_WR_GAP;
        end
      endcase
    endfunction

    function void advance(inout out_item_t r, input logic [7:0] m);
      case (phase)
        PH_WAKE: begin
          byte_count++;
          if (byte_count >= WAKE_BYTES) begin_command();
        end
        PH_CMD_DUMMY: begin
          byte_count = '0;
          phase = PH_CMD_SEND;
        end
        PH_CMD_SEND: begin
          byte_count++;
          if (byte_count >= 6) begin
            poll_count = '0;
            phase = PH_CMD_POLL;
          end
        end
        PH_CMD_POLL: poll_response(r, m);
        PH_GAP: begin
          op_kind = KIND_CMD1;
          begin_command();
        end
        PH_FINAL: finish_op(r, ST_OK);
        PH_TOKEN_WAIT: begin
          if (m == DATA_TOKEN) begin
            byte_count = '0;
            phase = PH_READ_DATA;
          end
        end
        PH_READ_DATA: begin
          if (byte_count >= window_first && byte_count < window_end) begin
            r.read_valid = 1'b1;
            r.read_byte = m;
            r.byte_index = byte_count[8:0];
            window_bytes++;
          end
          byte_count++;
          if (byte_count >= SECTOR_BYTES) begin
            byte_count = '0;
            phase = PH_CRC;
          end
        end
        PH_CRC: begin
          byte_count++;
          if (byte_count >= 2) phase = (op_kind == KIND_WRITE) ? PH_WR_RESP : PH_FINAL;
        end
        PH_WR_GAP: begin
          byte_count++;
          if (byte_count >= WRITE_GAP_BYTES) phase = PH_WR_TOKEN;
        end
        PH_WR_TOKEN: begin
          byte_count = '0;
          phase = PH_WR_DATA;
        end
        PH_WR_DATA: begin
          byte_count++;
          if (byte_count >= SECTOR_BYTES) begin
            byte_count = '0;
            phase = PH_CRC;
          end
        end
        PH_WR_RESP: begin
          if ((m & DRESP_MASK) != DRESP_OK) finish_op(r, ST_REJECTED);
          else phase = PH_WR_BUSY;
        end
        PH_WR_BUSY: begin
          if (m == IDLE_BYTE) phase = PH_FINAL;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void request_exchange(inout out_item_t r, input logic [7:0] wd);
      r.mosi_byte = IDLE_BYTE;
      r.select_active = 1'b1;
      case (phase)
        PH_WAKE, PH_CMD_DUMMY, PH_GAP, PH_FINAL: r.select_active = 1'b0;
        PH_CMD_SEND: r.mosi_byte = command_byte();
        PH_WR_TOKEN: begin
          r.mosi_byte = DATA_TOKEN;
          r.need_write_data = 1'b1;
          r.byte_index = '0;
        end
        PH_WR_DATA: begin
          r.mosi_byte = wd;
          if (byte_count < SECTOR_BYTES - 1) begin
            r.need_write_data = 1'b1;
            r.byte_index = byte_count[8:0] + 9'd1;
          end
        end
        default: ;
      endcase
      if (r.need_write_data) payload_requests++;
      r.exchange = 1'b1;
    endfunction

    function out_item_t next_exchange(in_item_t it);
      out_item_t r;
      logic [10:0] wsum;
      r = '0;
      case (it.operation)
        OP_INIT: begin
          if (!it.card_present) begin
            finish_op(r, ST_NO_CARD);
          end else begin
            clock_fast = 1'b0;
            op_kind = KIND_CMD0;
            byte_address = '0;
            byte_count = '0;
            phase = PH_WAKE;
          end
        end
        OP_READ, OP_WRITE: begin
          op_kind = (it.operation == OP_READ) ? KIND_READ : KIND_WRITE;
          byte_address = {it.sector, 9'd0};
          if (it.operation == OP_READ) begin
            wsum = 11'(it.window_start) + 11'(it.window_length);
            window_first = it.window_start;
            window_end = (wsum > SECTOR_BYTES) ? 10'(SECTOR_BYTES) : wsum[9:0];
          end else begin
            window_first = '0;
            window_end = '0;
          end
          begin_command();
        end
        default: advance(r, it.miso_byte);
      endcase
      if (phase != PH_IDLE) request_exchange(r, it.write_data);
      r.fast_clock = clock_fast;
      return r;
    endfunction

    function void take_beat(in_item_t it);
      beats_taken++;
      next_exchange_q.push_back(next_exchange(it));
    endfunction

    task log_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_field(string name, logic [8:0] got, logic [8:0] want);
      if (got !== want)
        log_mismatch($sformatf("result %0d %s: got %h, want %h",
                               results_checked, name, got, want));
    endtask

    task match_result(out_item_t got);
      out_item_t want;
      if (next_exchange_q.size() == 0) begin
        log_mismatch($sformatf("result beat %h with nothing outstanding", got));
        return;
      end
      want = next_exchange_q.pop_front();
      results_checked++;
      check_field("exchange", 9'(got.exchange), 9'(want.exchange));
      check_field("mosi_byte", 9'(got.mosi_byte), 9'(want.mosi_byte));
      check_field("select_active", 9'(got.select_active), 9'(want.select_active));
      check_field("fast_clock", 9'(got.fast_clock), 9'(want.fast_clock));
      check_field("read_byte", 9'(got.read_byte), 9'(want.read_byte));
      check_field("read_valid", 9'(got.read_valid), 9'(want.read_valid));
      check_field("byte_index", got.byte_index, want.byte_index);
      check_field("need_write_data", 9'(got.need_write_data), 9'(want.need_write_data));
      check_field("done_res", 9'(got.done_res), 9'(want.done_res));
      check_field("status", 9'(got.status), 9'(want.status));
      check_field("card_response", 9'(got.card_response), 9'(want.card_response));
    endtask

    task close_out();
      if (next_exchange_q.size() != 0)
        log_mismatch($sformatf("%0d results never arrived", next_exchange_q.size()));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [LIMIT_W-1:0]   cfg_write_data;
  int unsigned          src_idle_pct;
  int unsigned          rx_idle_pct;
  int unsigned          rx_hold;
  int unsigned          cycle_count;
  sd_sequencer_shadow   sb = new();

  sdspi_in_if  in_ch();
  sdspi_out_if out_ch();

  sd_spi_block_sequencer_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_item_t beat(logic [1:0] op, logic [22:0] sector, logic [8:0] ws,
                                    logic [9:0] wl, logic present, logic [7:0] miso,
                                    logic [7:0] wd);
    in_item_t it;
    it.operation     = op;
    it.sector        = sector;
    it.window_start  = ws;
    it.window_length = wl;
    it.card_present  = present;
    it.miso_byte     = miso;
    it.write_data    = wd;
    return it;
  endfunction

  function automatic in_item_t noise_beat();
    return beat(OP_XFER, 23'($urandom()), 9'($urandom()), 10'($urandom_range(0, 512)),
                1'($urandom()), 8'($urandom()), 8'($urandom()));
  endfunction

  function automatic in_item_t start_beat();
    in_item_t it;
    int unsigned pick;
    it = noise_beat();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.operation = OP_INIT;
      it.card_present = ($urandom_range(0, 9) != 0);
    end else if (pick < 65) begin
      it.operation = OP_READ;
      it.window_start = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'($urandom_range(0, 511));
      it.window_length = ($urandom_range(0, 4) == 0) ? 10'd512 : 10'($urandom_range(0, 512));
    end else begin
      it.operation = OP_WRITE;
    end
    return it;
  endfunction

  // Answer as a card would in the current phase, with some wrong answers mixed in
  function automatic in_item_t card_answer();
    in_item_t it;
    int unsigned roll;
    it = noise_beat();
    roll = $urandom_range(0, 99);
    case (sb.phase)
      PH_CMD_POLL: begin
        if (roll < 40) it.miso_byte = IDLE_BYTE;
        else if (roll < 88) it.miso_byte = (sb.op_kind == KIND_CMD0) ? R1_IDLE : R1_READY;
      end
      PH_TOKEN_WAIT: begin
        if (roll < 60) it.miso_byte = DATA_TOKEN;
        else if (roll < 85) it.miso_byte = IDLE_BYTE;
      end
      PH_WR_RESP: begin
        if (roll < 80) it.miso_byte = {it.miso_byte[7:5], DRESP_OK[4:0]};
      end
      PH_WR_BUSY: it.miso_byte = (roll < 55) ? 8'h00 : IDLE_BYTE;
      default: ;
    endcase
    return it;
  endfunction

  task automatic offer_beat(input in_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.take_beat(it);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_retry_limit(input logic [LIMIT_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_limit(v);
  endtask

  // Play the card side; some operations get cut short by a fresh start
  task automatic play_card(input int unsigned n_beats);
    int unsigned counted;
    int          abort_at;
    int          op_len;
    in_item_t    it;
    counted = 0;
    abort_at = -1;
    op_len = 0;
    while (counted < n_beats) begin
      if (sb.seq_idle() && $urandom_range(0, 19) == 0) begin
        it = noise_beat();
      end else if (sb.seq_idle() || op_len == abort_at) begin
        it = start_beat();
        counted++;
        op_len = 0;
        abort_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 650)) : -1;
      end else begin
        it = card_answer();
        counted++;
        op_len++;
      end
      offer_beat(it);
    end
  endtask

  // Result side: random back-pressure plus a long hold when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.match_result(out_ch.data);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= RETRY_LIMIT_RESET;
    in_ch.valid    <= 1'b0;
    in_ch.data     <= '0;
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    rx_hold      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: no card, stray beat while idle, read cut short by a write
    offer_beat(beat(OP_INIT, '0, '0, '0, 1'b0, 8'h00, 8'h00));
    offer_beat(beat(OP_XFER, '1, '1, 10'd512, 1'b1, IDLE_BYTE, 8'hFF));
    offer_beat(beat(OP_READ, '1, 9'd511, 10'd512, 1'b1, 8'h00, 8'h00));
    repeat (7) offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, IDLE_BYTE, 8'h00));
    offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, R1_READY, 8'h00));
    offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, DATA_TOKEN, 8'h00));
    offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, 8'h5A, 8'hA5));
    offer_beat(beat(OP_WRITE, '0, '0, '0, 1'b1, 8'h00, 8'h00));
    repeat (3) offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, IDLE_BYTE, 8'h00));

    // a zero limit behaves as one: a good first answer still fails
    settle();
    load_retry_limit('0);
    offer_beat(beat(OP_READ, 23'h2AAAAA, '0, '0, 1'b1, 8'h00, 8'h00));
    repeat (7) offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, IDLE_BYTE, 8'h00));
    offer_beat(beat(OP_XFER, '0, '0, '0, 1'b0, R1_READY, 8'h00));

    settle();
    src_idle_pct = 35;
    rx_idle_pct  = 72;
    load_retry_limit(LIMIT_W'(1));
    play_card(610);

    settle();
    src_idle_pct = 72;
    rx_idle_pct  = 35;
    load_retry_limit('1);
    play_card(610);

    // full rate; hold results off long enough for the input side to back up
    settle();
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    load_retry_limit(LIMIT_W'($urandom_range(2, 4)));
    rx_hold = 150;
    play_card(610);

    settle();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    sb.close_out();
    $display("covered %0d beats, %0d results checked, %0d window bytes, %0d payload requests",
             sb.beats_taken, sb.results_checked, sb.window_bytes, sb.payload_requests);
    $display("ops: ok %0d, no card %0d, cmd0 %0d, cmd1 %0d, rd %0d, wr %0d, rejected %0d",
             sb.finished_by_status[ST_OK], sb.finished_by_status[ST_NO_CARD],
             sb.finished_by_status[ST_CMD0_FAIL], sb.finished_by_status[ST_CMD1_FAIL],
             sb.finished_by_status[ST_READ_FAIL], sb.finished_by_status[ST_WR_FAIL],
             sb.finished_by_status[ST_REJECTED]);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sdspi_pkg.sv
sv/sdspi_if.sv
sv/sdspi_step.sv
sv/sd_spi_block_sequencer_top.sv
dv/tb_sd_spi_block_sequencer_top.sv
